### design/dpr_pkg.sv
// dpr_pkg: shared types and codes for the directory-entry page record decoder.
// Holds the phase enum, result kind and status codes, and the result struct.
// No dependencies.
package dpr_pkg;

	// decoder phase within a page
	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_PARENT  = 3'd1,
		PH_NAMELEN = 3'd2,
		PH_NAME    = 3'd3,
		PH_CHILD   = 3'd4,
		PH_TYPE    = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	// result kind, carried on tuser
	typedef enum logic [1:0] {
		KIND_NAME   = 2'd0,
		KIND_RECORD = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// page status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT_CNT = 3'd1,
		ST_TRUNC_HDR = 3'd2,
		ST_TRUNC_NAM = 3'd3,
		ST_TRUNC_TL  = 3'd4,
		ST_TRAILING  = 3'd5
	} status_t;

	localparam int unsigned DATA_W = 200;	// 195 payload bits padded to bytes

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  name_char;
		logic [63:0] parent_id;
		logic [63:0] child_id;
		logic [7:0]  entry_kind;
		logic [15:0] name_size;
		logic [31:0] record_total;
		status_t     status_code;
		logic        last_result;
	} result_t;

endpackage

### design/dentry_page_record_decoder_top.sv
// dentry_page_record_decoder_top: byte-stream decoder for directory-entry pages; needs dpr_pkg.
// Input register, single-pass field decode, result register and one pending status slot.
// A result beat is offered only after its input beat has passed the input and result registers.
// Throughput: one byte per cycle while m_tready holds; a byte with two results (name byte or
// record plus the page status) stalls the next input beat while the status beat drains.
// Reset: arst_n clears control and field state; each page's final byte returns to that state.
module dentry_page_record_decoder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] data_byte
	input  logic                       s_tlast,   // final_byte
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [dpr_pkg::DATA_W-1:0] m_tdata,   // [7:0] name_char, [71:8] parent_id,
	                                              // [135:72] child_id, [143:136] entry_kind,
	                                              // [159:144] name_size, [191:160] record_total,
	                                              // [194:192] status_code, rest zero
	output logic [1:0]                 m_tuser,   // kind
	output logic                       m_tlast    // last_result
);

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;
	logic       advance;	// s1 item is decoded and retired this cycle

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			fin_s1  <= s_tlast;
		end
	end

	// ---------------- decoder state ----------------
	dpr_pkg::phase_t phase_q, phase_d;
	logic [2:0]      byte_index_q, byte_index_d;
	logic [31:0]     entry_count_q, entry_count_d;
	logic [31:0]     entries_done_q, entries_done_d;
	logic [63:0]     parent_acc_q, parent_acc_d;
	logic [15:0]     name_len_acc_q, name_len_acc_d;
	logic [15:0]     name_left_q, name_left_d;
	logic [63:0]     child_acc_q, child_acc_d;
	logic            extra_seen_q, extra_seen_d;

	// decode results for the byte in s1
	dpr_pkg::result_t first_res, stat_res;
	logic             has_first;	// name byte or record result
	logic             two_res;	// first result plus trailing status

	always_comb begin
		phase_d        = phase_q;
		byte_index_d   = byte_index_q;
		entry_count_d  = entry_count_q;
		entries_done_d = entries_done_q;
		parent_acc_d   = parent_acc_q;
		name_len_acc_d = name_len_acc_q;
		name_left_d    = name_left_q;
		child_acc_d    = child_acc_q;
		extra_seen_d   = extra_seen_q;
		first_res      = '0;
		stat_res       = '0;
		has_first      = 1'b0;

		unique case (phase_q)
			dpr_pkg::PH_COUNT: begin
				entry_count_d = entry_count_q
					| ({24'd0, byte_s1} << {byte_index_q[1:0], 3'b000});
				if (byte_index_q[1:0] == 2'd3) begin
					byte_index_d = 3'd0;
					if (entry_count_d == 32'd0) begin
						phase_d = dpr_pkg::PH_DONE;
					end else begin
						phase_d        = dpr_pkg::PH_PARENT;
						parent_acc_d   = '0;
						name_len_acc_d = '0;
						name_left_d    = '0;
						child_acc_d    = '0;
					end
				end else begin
					byte_index_d = {1'b0, byte_index_q[1:0] + 2'd1};
				end
			end
			dpr_pkg::PH_PARENT: begin
				parent_acc_d = parent_acc_q | ({56'd0, byte_s1} << {byte_index_q, 3'b000});
				if (byte_index_q == 3'd7) begin
					phase_d      = dpr_pkg::PH_NAMELEN;
					byte_index_d = 3'd0;
				end else begin
					byte_index_d = byte_index_q + 3'd1;
				end
			end
			dpr_pkg::PH_NAMELEN: begin
				name_len_acc_d = name_len_acc_q
					| ({8'd0, byte_s1} << {byte_index_q[0], 3'b000});
				if (byte_index_q[0]) begin
					byte_index_d = 3'd0;
					name_left_d  = name_len_acc_d;
					phase_d      = (name_len_acc_d == 16'd0) ? dpr_pkg::PH_CHILD
					                                         : dpr_pkg::PH_NAME;
				end else begin
					byte_index_d = 3'd1;
				end
			end
			dpr_pkg::PH_NAME: begin
				has_first           = 1'b1;
				first_res.kind      = dpr_pkg::KIND_NAME;
				first_res.name_char = byte_s1;
				name_left_d         = name_left_q - 16'd1;
				if (name_left_d == 16'd0) begin
					phase_d      = dpr_pkg::PH_CHILD;
					byte_index_d = 3'd0;
				end
			end
			dpr_pkg::PH_CHILD: begin
				child_acc_d = child_acc_q | ({56'd0, byte_s1} << {byte_index_q, 3'b000});
				if (byte_index_q == 3'd7) begin
					phase_d      = dpr_pkg::PH_TYPE;
					byte_index_d = 3'd0;
				end else begin
					byte_index_d = byte_index_q + 3'd1;
				end
			end
			dpr_pkg::PH_TYPE: begin
				has_first              = 1'b1;
				first_res.kind         = dpr_pkg::KIND_RECORD;
				first_res.parent_id    = parent_acc_q;
				first_res.child_id     = child_acc_q;
				first_res.entry_kind   = byte_s1;
				first_res.name_size    = name_len_acc_q;
				first_res.record_total = entry_count_q;
				entries_done_d         = entries_done_q + 32'd1;
				byte_index_d           = 3'd0;
				if (entries_done_d == entry_count_q) begin
					phase_d = dpr_pkg::PH_DONE;
				end else begin
					phase_d        = dpr_pkg::PH_PARENT;
					parent_acc_d   = '0;
					name_len_acc_d = '0;
					name_left_d    = '0;
					child_acc_d    = '0;
				end
			end
			default: begin
				// past the last record, or the unused phase code
				extra_seen_d = 1'b1;
			end
		endcase

		// page status from the phase reached after this byte
		stat_res.kind         = dpr_pkg::KIND_STATUS;
		stat_res.record_total = entry_count_d;
		stat_res.last_result  = 1'b1;
		unique case (phase_d)
			dpr_pkg::PH_COUNT:   stat_res.status_code = dpr_pkg::ST_SHORT_CNT;
			dpr_pkg::PH_PARENT,
			dpr_pkg::PH_NAMELEN: stat_res.status_code = dpr_pkg::ST_TRUNC_HDR;
			dpr_pkg::PH_NAME:    stat_res.status_code = dpr_pkg::ST_TRUNC_NAM;
			dpr_pkg::PH_CHILD,
			dpr_pkg::PH_TYPE:    stat_res.status_code = dpr_pkg::ST_TRUNC_TL;
			default: stat_res.status_code = extra_seen_d ? dpr_pkg::ST_TRAILING
			                                             : dpr_pkg::ST_OK;
		endcase

		first_res.last_result = !fin_s1;
		two_res               = has_first && fin_s1;

		// final byte: back to the start of a page
		if (fin_s1) begin
			phase_d        = dpr_pkg::PH_COUNT;
			byte_index_d   = '0;
			entry_count_d  = '0;
			entries_done_d = '0;
			parent_acc_d   = '0;
			name_len_acc_d = '0;
			name_left_d    = '0;
			child_acc_d    = '0;
			extra_seen_d   = 1'b0;
		end
	end

	// ---------------- output register and pending status ----------------
	logic             out_valid_q;
	dpr_pkg::result_t out_q;
	logic             pend_q;		// status beat waiting behind the output register
	dpr_pkg::result_t pend_res_q;
	logic             out_free;
	logic             emits;		// s1 byte yields at least one result

	assign out_free = !out_valid_q || m_tready;
	assign emits    = has_first || fin_s1;
	// a byte with no result needs no output slot, others do; none retires while a status is pending
	assign advance  = valid_s1 && !pend_q && (!emits || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= dpr_pkg::PH_COUNT;
			byte_index_q   <= '0;
			entry_count_q  <= '0;
			entries_done_q <= '0;
			parent_acc_q   <= '0;
			name_len_acc_q <= '0;
			name_left_q    <= '0;
			child_acc_q    <= '0;
			extra_seen_q   <= 1'b0;
		end else if (advance) begin
			phase_q        <= phase_d;
			byte_index_q   <= byte_index_d;
			entry_count_q  <= entry_count_d;
			entries_done_q <= entries_done_d;
			parent_acc_q   <= parent_acc_d;
			name_len_acc_q <= name_len_acc_d;
			name_left_q    <= name_left_d;
			child_acc_q    <= child_acc_d;
			extra_seen_q   <= extra_seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (pend_q && out_free) begin
			out_valid_q <= 1'b1;
			pend_q      <= 1'b0;
		end else if (advance && emits) begin
			out_valid_q <= 1'b1;
			pend_q      <= two_res;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && out_free) begin
			out_q <= pend_res_q;
		end else if (advance && emits) begin
			out_q <= has_first ? first_res : stat_res;
		end
		if (advance && two_res) begin
			pend_res_q <= stat_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last_result;
	assign m_tdata  = {5'd0, out_q.status_code, out_q.record_total, out_q.name_size,
	                   out_q.entry_kind, out_q.child_id, out_q.parent_id, out_q.name_char};

`ifndef SYNTH
	// pending status only ever sits behind a held result
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("pending status without held result");

	// the beat in front of a pending status is not the last of its byte
	a_pend_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !m_tlast)
		else $error("result ahead of pending status marked last");

	// a status beat always closes its byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == dpr_pkg::KIND_STATUS) |-> m_tlast)
		else $error("status beat not marked last");

	// name phase always has bytes left to take
	a_name_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dpr_pkg::PH_NAME) |-> (name_left_q != 16'd0))
		else $error("name phase with no bytes left");

	// count field index stays within four bytes
	a_count_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dpr_pkg::PH_COUNT) |-> (byte_index_q[2] == 1'b0))
		else $error("count byte index out of range");
`endif

endmodule

### test/testbench.sv
// testbench: self-checking bench for dentry_page_record_decoder_top.
// Streams directory-entry pages byte by byte, predicts every result beat and checks it.
// Depends on dpr_pkg and the decoder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 500;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata = 8'h00;   // [7:0] data_byte
	logic                        s_tlast = 1'b0;    // final_byte
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [dpr_pkg::DATA_W-1:0]  m_tdata;           // [7:0] name_char, [71:8] parent_id,
	                                                // [135:72] child_id, [143:136] entry_kind,
	                                                // [159:144] name_size,
	                                                // [191:160] record_total,
	                                                // [194:192] status_code
	logic [1:0]                  m_tuser;           // kind
	logic                        m_tlast;           // last_result

	dentry_page_record_decoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// decoder state as predicted by the bench
	dpr_pkg::phase_t dec_phase;
	logic [2:0]      dec_idx;
	logic [31:0]     dec_count;
	logic [31:0]     dec_done;
	logic [63:0]     par_acc;
	logic [15:0]     len_acc;
	logic [15:0]     len_left;
	logic [63:0]     chi_acc;
	logic            extra;

	dpr_pkg::result_t pending_results [$];
	dpr_pkg::result_t want;
	logic [7:0]       page_q [$];
	int               err_count = 0;
	int               sent_bytes = 0;
	int               idle_cycles;
	int               rx_wait = 0;
	int               rx_next;
	bit               steady = 1'b0;	// no idling on either side while set

	task clear_decoder();
		dec_phase = dpr_pkg::PH_COUNT;
		dec_idx   = '0;
		dec_count = '0;
		dec_done  = '0;
		par_acc   = '0;
		len_acc   = '0;
		len_left  = '0;
		chi_acc   = '0;
		extra     = 1'b0;
	endtask

	task open_record();
		dec_phase = dpr_pkg::PH_PARENT;
		dec_idx   = '0;
		par_acc   = '0;
		len_acc   = '0;
		len_left  = '0;
		chi_acc   = '0;
	endtask

	// expected result beats for one accepted input beat
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		dpr_pkg::result_t res [2];
		int               n;
		dpr_pkg::status_t code;
		logic [2:0]       idx;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		idx = dec_idx;
		case (dec_phase)
		dpr_pkg::PH_COUNT: begin
			dec_count = dec_count | (32'(b) << (8 * idx[1:0]));
			if (idx[1:0] == 2'd3) begin
				if (dec_count == 0) begin
					dec_phase = dpr_pkg::PH_DONE;
					dec_idx = '0;
				end else begin
					open_record();
				end
			end else begin
				dec_idx = {1'b0, idx[1:0]} + 3'd1;
			end
		end
		dpr_pkg::PH_PARENT: begin
			par_acc = par_acc | (64'(b) << (8 * idx));
			if (idx == 3'd7) begin
				dec_phase = dpr_pkg::PH_NAMELEN;
				dec_idx = '0;
			end else begin
				dec_idx = idx + 3'd1;
			end
		end
		dpr_pkg::PH_NAMELEN: begin
			len_acc = len_acc | (16'(b) << (8 * idx[0]));
			if (idx[0]) begin
				dec_idx = '0;
				len_left = len_acc;
				dec_phase = (len_left == 0) ? dpr_pkg::PH_CHILD : dpr_pkg::PH_NAME;
			end else begin
				dec_idx = 3'd1;
			end
		end
		dpr_pkg::PH_NAME: begin
			res[n].kind = dpr_pkg::KIND_NAME;
			res[n].name_char = b;
			n++;
			len_left = len_left - 16'd1;
			if (len_left == 0) begin
				dec_phase = dpr_pkg::PH_CHILD;
				dec_idx = '0;
			end
		end
		dpr_pkg::PH_CHILD: begin
			chi_acc = chi_acc | (64'(b) << (8 * idx));
			if (idx == 3'd7) begin
				dec_phase = dpr_pkg::PH_TYPE;
				dec_idx = '0;
			end else begin
				dec_idx = idx + 3'd1;
			end
		end
		dpr_pkg::PH_TYPE: begin
			res[n].kind = dpr_pkg::KIND_RECORD;
			res[n].parent_id = par_acc;
			res[n].child_id = chi_acc;
			res[n].entry_kind = b;
			res[n].name_size = len_acc;
			res[n].record_total = dec_count;
			n++;
			dec_done = dec_done + 32'd1;
			if (dec_done == dec_count) begin
				dec_phase = dpr_pkg::PH_DONE;
				dec_idx = '0;
			end else begin
				open_record();
			end
		end
		default: begin
			// past the last record, or an unused phase code
			extra = 1'b1;
		end
		endcase
		if (fin) begin
			case (dec_phase)
			dpr_pkg::PH_COUNT:   code = dpr_pkg::ST_SHORT_CNT;
			dpr_pkg::PH_PARENT,
			dpr_pkg::PH_NAMELEN: code = dpr_pkg::ST_TRUNC_HDR;
			dpr_pkg::PH_NAME:    code = dpr_pkg::ST_TRUNC_NAM;
			dpr_pkg::PH_CHILD,
			dpr_pkg::PH_TYPE:    code = dpr_pkg::ST_TRUNC_TL;
			default:             code = extra ? dpr_pkg::ST_TRAILING : dpr_pkg::ST_OK;
			endcase
			res[n].kind = dpr_pkg::KIND_STATUS;
			res[n].record_total = dec_count;
			res[n].status_code = code;
			n++;
			clear_decoder();
		end
		if (n > 0)
			res[n-1].last_result = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.insert(pending_results.size(), res[i]);
	endtask

	function automatic int draw_gap();
		if (steady)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	// one input beat; prediction is taken at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(b, fin);
		sent_bytes++;
	endtask

	task automatic push_le(input logic [63:0] v, input int nb);
		for (int i = 0; i < nb; i++)
			page_q.insert(page_q.size(), v[8*i +: 8]);
	endtask

	task automatic add_record(input logic [63:0] par, input int nlen, input logic [63:0] chi,
			input logic [7:0] kind_byte);
		push_le(par, 8);
		push_le(64'(nlen), 2);
		repeat (nlen) page_q.insert(page_q.size(), 8'($urandom_range(0, 255)));
		push_le(chi, 8);
		page_q.insert(page_q.size(), kind_byte);
	endtask

	// sends the first len bytes of the built page, final flag on the last one
	task automatic send_page(input int len);
		for (int i = 0; i < len; i++)
			send_byte(page_q[i], i == len - 1);
		page_q.delete();
	endtask

	// sender holds off until every expected beat has come back
	task drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task test_count_field();
		push_le(64'hFF, 1);              // final on first count byte
		send_page(1);
		push_le(64'h5A_A5_00, 3);        // final on third count byte
		send_page(3);
		push_le(64'h0, 4);               // zero count, clean page
		send_page(4);
		push_le(64'h0, 4);               // zero count, then trailing bytes
		push_le(64'h80_7F, 2);
		send_page(6);
		push_le(64'hFFFF_FFFF, 4);       // count ends, final where a record should begin
		send_page(4);
	endtask

	task test_full_records();
		push_le(64'd2, 4);
		add_record(64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0, 8'hFF);
		add_record(64'h0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);   // empty name
		send_page(page_q.size());
	endtask

	task automatic test_truncated_pages();
		// one record with a 4-byte name: count 0..3, parent 4..11, length 12..13,
		// name 14..17, child 18..25, type 26
		int lens [5] = '{7, 14, 16, 18, 26};
		foreach (lens[i]) begin
			push_le(64'd1, 4);
			add_record({$urandom(), $urandom()}, 4, {$urandom(), $urandom()}, 8'h3C);
			send_page(lens[i]);
		end
		// two records expected, final on the type byte of the first
		push_le(64'd2, 4);
		add_record({$urandom(), $urandom()}, 0, {$urandom(), $urandom()}, 8'hC3);
		send_page(page_q.size());
		// largest name length, cut after three name bytes
		push_le(64'hFFFF_FFFF, 4);
		push_le({$urandom(), $urandom()}, 8);
		push_le(64'hFFFF, 2);
		push_le(64'h00_FF_80, 3);
		send_page(page_q.size());
	endtask

	task test_trailing_bytes();
		push_le(64'd1, 4);
		add_record({$urandom(), $urandom()}, 2, {$urandom(), $urandom()}, 8'h01);
		push_le(64'hAB_CD_EF, 3);
		send_page(page_q.size());
	endtask

	task test_long_name();
		// both length bytes nonzero
		push_le(64'd1, 4);
		add_record({$urandom(), $urandom()}, 258, {$urandom(), $urandom()}, 8'h7E);
		send_page(page_q.size());
	endtask

	task automatic test_random_pages();
		int goal;
		int sel;
		int nrec;
		int nlen;
		int cut;
		// random pages fill the run up to about 550 input beats
		goal = 550;
		while (sent_bytes < goal) begin
			steady = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				// noise: one to ten random bytes; a full count field is almost always huge
				repeat ($urandom_range(1, 10))
					page_q.insert(page_q.size(), 8'($urandom_range(0, 255)));
				send_page(page_q.size());
			end else begin
				nrec = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
				push_le(64'(nrec), 4);
				repeat (nrec) begin
					nlen = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40)
					                                   : $urandom_range(0, 6);
					add_record({$urandom(), $urandom()}, nlen, {$urandom(), $urandom()},
						8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3))
						page_q.insert(page_q.size(), 8'($urandom_range(0, 255)));
				// about a fifth of the pages are cut short
				cut = (sel < 32) ? $urandom_range(1, page_q.size()) : page_q.size();
				send_page(cut);
			end
			if ($urandom_range(0, 15) == 0)
				drain();
		end
		steady = 1'b0;
	endtask

	// result side: random stall after each accepted beat, none while steady is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			rx_next = (m_tvalid && m_tready) ? draw_gap() : rx_wait;
			if (rx_next > 0) begin
				m_tready <= 1'b0;
				rx_wait <= rx_next - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want_v, got_v);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got kind %0d data %0h",
					$time, m_tuser, m_tdata);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("name_char", want.name_char, m_tdata[7:0]);
				check_field("parent_id", want.parent_id, m_tdata[71:8]);
				check_field("child_id", want.child_id, m_tdata[135:72]);
				check_field("entry_kind", want.entry_kind, m_tdata[143:136]);
				check_field("name_size", want.name_size, m_tdata[159:144]);
				check_field("record_total", want.record_total, m_tdata[191:160]);
				check_field("status_code", want.status_code, m_tdata[194:192]);
				check_field("last_result", want.last_result, m_tlast);
			end
		end
	end

	// ends the run after too many cycles with no beat on either side
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		clear_decoder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_count_field();
		drain();
		test_full_records();
		drain();
		test_truncated_pages();
		test_trailing_bytes();
		drain();
		test_long_name();
		test_random_pages();
		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### filelist.f
design/dpr_pkg.sv
design/dentry_page_record_decoder_top.sv
test/testbench.sv
